FILE: sv/optimal_bst_builder_macros.svh
// Assertion macros shared by the optimal BST builder RTL.
`ifndef OPTIMAL_BST_BUILDER_MACROS_SVH
`define OPTIMAL_BST_BUILDER_MACROS_SVH
`ifndef SYNTHESIS
`define OBB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obb assertion failed");
`define OBB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obb assertion failed");
`else
`define OBB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OBB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/obb_pkg.sv
// Package: types, sizes and helper functions of the optimal BST builder.
`default_nettype none
package obb_pkg;
    localparam int MAX_KEYS   = 16;
    localparam int ROWS       = MAX_KEYS + 2;
    localparam int COLS       = MAX_KEYS + 1;
    localparam int IDX_W      = $clog2(MAX_KEYS + 2);
    localparam int KEY_AW     = $clog2(MAX_KEYS);
    localparam int TAB_DEPTH  = ROWS * COLS;
    localparam int TAB_AW     = $clog2(TAB_DEPTH);
    localparam int COST_W     = 32;
    localparam int WEIGHT_W   = 16;
    localparam int KEY_W      = 32;

    typedef struct packed {
        logic [15:0]        failure_weight;
        logic [15:0]        success_weight;
        logic signed [31:0] key_value;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [4:0]         node_index;
        logic signed [31:0] node_key;
        logic [4:0]         left_index;
        logic [4:0]         right_index;
        logic [31:0]        total_cost;
        logic               overflow;
        logic               final_node;
    } result_t;

    // load and start request from the front end to the engine
    typedef struct packed {
        logic                we;
        logic [IDX_W-1:0]    idx;
        logic [WEIGHT_W-1:0] q;
        logic [WEIGHT_W-1:0] p;
        logic [KEY_W-1:0]    key;
        logic                start;
        logic [IDX_W-1:0]    n;
        logic                ovf;
    } load_t;

    function automatic logic [TAB_AW-1:0] tab_addr(input logic [IDX_W-1:0] i,
                                                   input logic [IDX_W-1:0] j);
        logic [TAB_AW-1:0] a;
        a = TAB_AW'(i) * TAB_AW'(COLS) + TAB_AW'(j);
        return a;
    endfunction

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
    endfunction
endpackage
`default_nettype wire

FILE: sv/obb_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
`default_nettype none
module obb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic                     re_b,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end
endmodule
`default_nettype wire

FILE: sv/obb_engine.sv
// Engine: table memories, Knuth DP sequencer and preorder tree walk.
`default_nettype none
module obb_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire obb_pkg::load_t  ld,
    output logic                 busy,
    output obb_pkg::result_t     result,
    output logic                 result_valid,
    input  wire logic            result_ready
);
    localparam int IW = obb_pkg::IDX_W;
    localparam int TW = obb_pkg::TAB_AW;
    localparam int CW = obb_pkg::COST_W;
    localparam int KA = obb_pkg::KEY_AW;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_INIT_RD = 5'd1;
    localparam logic [4:0] S_INIT_WR = 5'd2;
    localparam logic [4:0] S_CELL_RD = 5'd3;
    localparam logic [4:0] S_CELL_W  = 5'd4;
    localparam logic [4:0] S_CAND_RD = 5'd5;
    localparam logic [4:0] S_CAND_EV = 5'd6;
    localparam logic [4:0] S_CELL_WR = 5'd7;
    localparam logic [4:0] S_TOT_RD  = 5'd8;
    localparam logic [4:0] S_TOT     = 5'd9;
    localparam logic [4:0] S_POP     = 5'd10;
    localparam logic [4:0] S_POP_RD  = 5'd11;
    localparam logic [4:0] S_NODE_RD = 5'd12;
    localparam logic [4:0] S_EMIT    = 5'd13;
    localparam logic [4:0] S_PUSHL   = 5'd14;
    localparam logic [4:0] S_Z_RD    = 5'd15;
    localparam logic [4:0] S_Z_EMIT  = 5'd16;

    logic [4:0]    state_reg, state_next;
    logic [IW-1:0] n_reg, n_next;
    logic          ovf_reg, ovf_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] len_reg, len_next;
    logic [IW-1:0] r_reg, r_next;
    logic [IW-1:0] hi_reg, hi_next;
    logic [CW-1:0] best_reg, best_next;
    logic [IW-1:0] broot_reg, broot_next;
    logic          found_reg, found_next;
    logic [CW-1:0] wij_reg, wij_next;
    logic [CW-1:0] total_reg, total_next;
    logic [IW-1:0] sp_reg, sp_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] wi_reg, wi_next;
    logic [IW-1:0] wj_reg, wj_next;
    logic [IW-1:0] wr_reg, wr_next;
    obb_pkg::result_t res_reg, res_next;
    logic          res_valid_reg, res_valid_next;

    // memory ports
    logic [15:0]     gap_rd, hit_rd;
    logic            gap_re, hit_re;
    logic [IW-1:0]   gap_ra, hit_ra;
    logic [31:0]     key_rd;
    logic            key_re;
    logic [KA-1:0]   key_ra;
    logic            cost_we, cost_re;
    logic [TW-1:0]   cost_wa, cost_ra, cost_rb;
    logic [CW-1:0]   cost_wd, cost_rda, cost_rdb;
    logic            wsum_we, wsum_re;
    logic [TW-1:0]   wsum_wa, wsum_ra;
    logic [CW-1:0]   wsum_wd, wsum_rd;
    logic            root_we, root_re_a, root_re_b;
    logic [TW-1:0]   root_wa, root_ra, root_rb;
    logic [IW-1:0]   root_wd, root_rda, root_rdb;
    logic            stk_we, stk_re;
    logic [KA-1:0]   stk_wa, stk_ra;
    logic [2*IW-1:0] stk_wd, stk_rd;

    logic [IW-1:0]   j_cur;
    logic [IW-1:0]   lo_c, hi_c;
    logic [CW-1:0]   cand_c;
    logic [IW-1:0]   sp_after;
    logic            out_free;

    obb_ram #(.WIDTH(16), .DEPTH(obb_pkg::MAX_KEYS + 1)) u_gap (
        .clk(clk), .we(ld.we), .waddr(ld.idx), .wdata(ld.q),
        .re_a(gap_re), .raddr_a(gap_ra), .rdata_a(gap_rd),
        .re_b(1'b0), .raddr_b(gap_ra), .rdata_b()
    );
    obb_ram #(.WIDTH(16), .DEPTH(obb_pkg::MAX_KEYS + 1)) u_hit (
        .clk(clk), .we(ld.we && (ld.idx != '0)), .waddr(ld.idx), .wdata(ld.p),
        .re_a(hit_re), .raddr_a(hit_ra), .rdata_a(hit_rd),
        .re_b(1'b0), .raddr_b(hit_ra), .rdata_b()
    );
    logic [IW-1:0] key_widx;
    assign key_widx = ld.idx - IW'(1);
    obb_ram #(.WIDTH(32), .DEPTH(obb_pkg::MAX_KEYS)) u_key (
        .clk(clk), .we(ld.we && (ld.idx != '0)), .waddr(key_widx[KA-1:0]),
        .wdata(ld.key),
        .re_a(key_re), .raddr_a(key_ra), .rdata_a(key_rd),
        .re_b(1'b0), .raddr_b(key_ra), .rdata_b()
    );
    obb_ram #(.WIDTH(CW), .DEPTH(obb_pkg::TAB_DEPTH)) u_cost (
        .clk(clk), .we(cost_we), .waddr(cost_wa), .wdata(cost_wd),
        .re_a(cost_re), .raddr_a(cost_ra), .rdata_a(cost_rda),
        .re_b(cost_re), .raddr_b(cost_rb), .rdata_b(cost_rdb)
    );
    obb_ram #(.WIDTH(CW), .DEPTH(obb_pkg::TAB_DEPTH)) u_wsum (
        .clk(clk), .we(wsum_we), .waddr(wsum_wa), .wdata(wsum_wd),
        .re_a(wsum_re), .raddr_a(wsum_ra), .rdata_a(wsum_rd),
        .re_b(1'b0), .raddr_b(wsum_ra), .rdata_b()
    );
    obb_ram #(.WIDTH(IW), .DEPTH(obb_pkg::TAB_DEPTH)) u_root (
        .clk(clk), .we(root_we), .waddr(root_wa), .wdata(root_wd),
        .re_a(root_re_a), .raddr_a(root_ra), .rdata_a(root_rda),
        .re_b(root_re_b), .raddr_b(root_rb), .rdata_b(root_rdb)
    );
    obb_ram #(.WIDTH(2 * IW), .DEPTH(obb_pkg::MAX_KEYS)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
        .re_a(stk_re), .raddr_a(stk_ra), .rdata_a(stk_rd),
        .re_b(1'b0), .raddr_b(stk_ra), .rdata_b()
    );

    always_comb
    begin
        j_cur    = i_reg + len_reg - IW'(1);
        out_free = !res_valid_reg || result_ready;
        lo_c     = (len_reg > IW'(1)) ? root_rda : i_reg;
        hi_c     = (len_reg > IW'(1)) ? root_rdb : j_cur;
        if (lo_c < i_reg)
        begin
            lo_c = i_reg;
        end
        if (hi_c > j_cur)
        begin
            hi_c = j_cur;
        end
        // empty range: take root i alone
        if (lo_c > hi_c)
        begin
            lo_c = i_reg;
            hi_c = i_reg;
        end
        cand_c   = obb_pkg::sat_add(obb_pkg::sat_add(cost_rda, cost_rdb), wij_reg);
        sp_after = sp_reg + ((wr_reg > wi_reg) ? IW'(1) : IW'(0));
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        len_next       = len_reg;
        r_next         = r_reg;
        hi_next        = hi_reg;
        best_next      = best_reg;
        broot_next     = broot_reg;
        found_next     = found_reg;
        wij_next       = wij_reg;
        total_next     = total_reg;
        sp_next        = sp_reg;
        k_next         = k_reg;
        wi_next        = wi_reg;
        wj_next        = wj_reg;
        wr_next        = wr_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !result_ready;

        gap_re = 1'b0;  gap_ra = '0;
        hit_re = 1'b0;  hit_ra = '0;
        key_re = 1'b0;  key_ra = '0;
        cost_we = 1'b0; cost_wa = '0; cost_wd = '0;
        cost_re = 1'b0; cost_ra = '0; cost_rb = '0;
        wsum_we = 1'b0; wsum_wa = '0; wsum_wd = '0;
        wsum_re = 1'b0; wsum_ra = '0;
        root_we = 1'b0; root_wa = '0; root_wd = '0;
        root_re_a = 1'b0; root_ra = '0;
        root_re_b = 1'b0; root_rb = '0;
        stk_we = 1'b0;  stk_wa = '0; stk_wd = '0;
        stk_re = 1'b0;  stk_ra = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (ld.start)
                begin
                    n_next   = ld.n;
                    ovf_next = ld.ovf;
                    i_next   = IW'(1);
                    state_next = (ld.n == '0) ? S_Z_RD : S_INIT_RD;
                end
            end
            S_INIT_RD:
            begin
                gap_re = 1'b1;
                gap_ra = i_reg - IW'(1);
                state_next = S_INIT_WR;
            end
            S_INIT_WR:
            begin
                cost_we = 1'b1;
                cost_wa = obb_pkg::tab_addr(i_reg, i_reg - IW'(1));
                cost_wd = CW'(gap_rd);
                wsum_we = 1'b1;
                wsum_wa = cost_wa;
                wsum_wd = CW'(gap_rd);
                if (i_reg == n_reg + IW'(1))
                begin
                    i_next   = IW'(1);
                    len_next = IW'(1);
                    state_next = S_CELL_RD;
                end
                else
                begin
                    i_next = i_reg + IW'(1);
                    state_next = S_INIT_RD;
                end
            end
            S_CELL_RD:
            begin
                wsum_re = 1'b1;
                wsum_ra = obb_pkg::tab_addr(i_reg, j_cur - IW'(1));
                hit_re = 1'b1;
                hit_ra = j_cur;
                gap_re = 1'b1;
                gap_ra = j_cur;
                root_re_a = 1'b1;
                root_ra = obb_pkg::tab_addr(i_reg, j_cur - IW'(1));
                root_re_b = 1'b1;
                root_rb = obb_pkg::tab_addr(i_reg + IW'(1), j_cur);
                state_next = S_CELL_W;
            end
            S_CELL_W:
            begin
                wij_next = obb_pkg::sat_add(wsum_rd, CW'({1'b0, hit_rd} + {1'b0, gap_rd}));
                wsum_we = 1'b1;
                wsum_wa = obb_pkg::tab_addr(i_reg, j_cur);
                wsum_wd = wij_next;
                r_next = lo_c;
                hi_next = hi_c;
                found_next = 1'b0;
                state_next = S_CAND_RD;
            end
            S_CAND_RD:
            begin
                cost_re = 1'b1;
                cost_ra = obb_pkg::tab_addr(i_reg, r_reg - IW'(1));
                cost_rb = obb_pkg::tab_addr(r_reg + IW'(1), j_cur);
                state_next = S_CAND_EV;
            end
            S_CAND_EV:
            begin
                // first strict minimum wins
                if (!found_reg || (cand_c < best_reg))
                begin
                    best_next  = cand_c;
                    broot_next = r_reg;
                    found_next = 1'b1;
                end
                if (r_reg == hi_reg)
                begin
                    state_next = S_CELL_WR;
                end
                else
                begin
                    r_next = r_reg + IW'(1);
                    state_next = S_CAND_RD;
                end
            end
            S_CELL_WR:
            begin
                cost_we = 1'b1;
                cost_wa = obb_pkg::tab_addr(i_reg, j_cur);
                cost_wd = best_reg;
                root_we = 1'b1;
                root_wa = cost_wa;
                root_wd = broot_reg;
                if (j_cur == n_reg)
                begin
                    if (len_reg == n_reg)
                    begin
                        state_next = S_TOT_RD;
                    end
                    else
                    begin
                        len_next = len_reg + IW'(1);
                        i_next = IW'(1);
                        state_next = S_CELL_RD;
                    end
                end
                else
                begin
                    i_next = i_reg + IW'(1);
                    state_next = S_CELL_RD;
                end
            end
            S_TOT_RD:
            begin
                cost_re = 1'b1;
                cost_ra = obb_pkg::tab_addr(IW'(1), n_reg);
                cost_rb = cost_ra;
                state_next = S_TOT;
            end
            S_TOT:
            begin
                total_next = cost_rda;
                stk_we = 1'b1;
                stk_wa = '0;
                stk_wd = {IW'(1), n_reg};
                sp_next = IW'(1);
                k_next = '0;
                state_next = S_POP;
            end
            S_POP:
            begin
                sp_next = sp_reg - IW'(1);
                stk_re = 1'b1;
                stk_ra = sp_next[KA-1:0];
                state_next = S_POP_RD;
            end
            S_POP_RD:
            begin
                wi_next = stk_rd[2*IW-1:IW];
                wj_next = stk_rd[IW-1:0];
                root_re_a = 1'b1;
                root_ra = obb_pkg::tab_addr(wi_next, wj_next);
                state_next = S_NODE_RD;
            end
            S_NODE_RD:
            begin
                wr_next = root_rda;
                root_re_a = 1'b1;
                root_ra = obb_pkg::tab_addr(wi_reg, root_rda - IW'(1));
                root_re_b = 1'b1;
                root_rb = (root_rda < wj_reg) ?
                          obb_pkg::tab_addr(root_rda + IW'(1), wj_reg) : '0;
                key_re = 1'b1;
                key_ra = KA'(root_rda - IW'(1));
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    res_next.node_index  = 5'(wr_reg);
                    res_next.node_key    = key_rd;
                    res_next.left_index  = (wr_reg > wi_reg) ? 5'(root_rda) : 5'd0;
                    res_next.right_index = (wr_reg < wj_reg) ? 5'(root_rdb) : 5'd0;
                    res_next.total_cost  = total_reg;
                    res_next.overflow    = ovf_reg;
                    res_next.final_node  = (k_reg + IW'(1) == n_reg);
                    res_valid_next = 1'b1;
                    k_next = k_reg + IW'(1);
                    // push right subtree first so left pops first
                    if (wr_reg < wj_reg)
                    begin
                        stk_we = 1'b1;
                        stk_wa = sp_reg[KA-1:0];
                        stk_wd = {wr_reg + IW'(1), wj_reg};
                        sp_next = sp_reg + IW'(1);
                    end
                    state_next = S_PUSHL;
                end
            end
            S_PUSHL:
            begin
                if (wr_reg > wi_reg)
                begin
                    stk_we = 1'b1;
                    stk_wa = sp_reg[KA-1:0];
                    stk_wd = {wi_reg, wr_reg - IW'(1)};
                end
                sp_next = sp_after;
                state_next = (sp_after == '0) ? S_IDLE : S_POP;
            end
            S_Z_RD:
            begin
                gap_re = 1'b1;
                gap_ra = '0;
                state_next = S_Z_EMIT;
            end
            S_Z_EMIT:
            begin
                if (out_free)
                begin
                    res_next.node_index  = 5'd0;
                    res_next.node_key    = '0;
                    res_next.left_index  = 5'd0;
                    res_next.right_index = 5'd0;
                    res_next.total_cost  = CW'(gap_rd);
                    res_next.overflow    = ovf_reg;
                    res_next.final_node  = 1'b1;
                    res_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            sp_reg        <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            sp_reg        <= sp_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        ovf_reg   <= ovf_next;
        i_reg     <= i_next;
        len_reg   <= len_next;
        r_reg     <= r_next;
        hi_reg    <= hi_next;
        best_reg  <= best_next;
        broot_reg <= broot_next;
        found_reg <= found_next;
        wij_reg   <= wij_next;
        total_reg <= total_next;
        wi_reg    <= wi_next;
        wj_reg    <= wj_next;
        wr_reg    <= wr_next;
        res_reg   <= res_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result       = res_reg;
    assign result_valid = res_valid_reg;
endmodule
`default_nettype wire

FILE: sv/optimal_bst_builder.sv
// Top level: request intake, item counting and the DP/tree-walk engine.
//
//  channel | direction | handshake                    | payload
//  item    | in        | item_valid / item_ready      | obb_pkg::item_t
//  result  | out       | result_valid / result_ready  | obb_pkg::result_t
//
// Load requests are taken one per cycle while the engine is idle.
// The request marked last starts the engine; intake then stalls until the
// tree walk is done. The DP seeds the tables with a read and a write per gap
// entry, reads, sums and writes each table cell, reads then compares each
// candidate root (reads are registered); the walk pops, reads, emits, pushes.
// A stalled result holds the walk in place.
// Reset clears the counters and the sequencer; table memories are not cleared.
`default_nettype none
`include "optimal_bst_builder_macros.svh"
module optimal_bst_builder (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire obb_pkg::item_t   item,
    input  wire logic             item_valid,
    output logic                  item_ready,
    output obb_pkg::result_t      result,
    output logic                  result_valid,
    input  wire logic             result_ready
);
    localparam int IW = obb_pkg::IDX_W;

    logic [IW-1:0]  item_count_reg, item_count_next;
    logic           overflow_reg, overflow_next;
    logic           accept;
    logic           room;
    logic [IW-1:0]  cnt_after;
    logic           ovf_after;
    logic           busy;
    obb_pkg::load_t ld;

    // hold intake while the engine works on a tree
    assign item_ready = !busy;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        room      = (item_count_reg <= IW'(obb_pkg::MAX_KEYS));
        cnt_after = room ? item_count_reg + IW'(1) : item_count_reg;
        ovf_after = overflow_reg || !room;

        // store the request while there is room, drop it otherwise
        ld.we    = accept && room;
        ld.idx   = item_count_reg;
        ld.q     = item.failure_weight;
        ld.p     = item.success_weight;
        ld.key   = item.key_value;
        ld.start = accept && item.last;
        ld.n     = cnt_after - IW'(1);
        ld.ovf   = ovf_after;

        item_count_next = item_count_reg;
        overflow_next   = overflow_reg;
        if (accept)
        begin
            // clear the counters for the next tree on the last request
            item_count_next = item.last ? '0 : cnt_after;
            overflow_next   = item.last ? 1'b0 : ovf_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            item_count_reg <= item_count_next;
            overflow_reg   <= overflow_next;
        end
    end

    obb_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .ld           (ld),
        .busy         (busy),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    `OBB_ASSERT_NXT(a_start_busy, clk, rst_n, accept && item.last, !item_ready)
    `OBB_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1,
                    item_count_reg <= IW'(obb_pkg::MAX_KEYS + 1))
    `OBB_ASSERT_IMP(a_ovf_full, clk, rst_n, overflow_reg,
                    item_count_reg == IW'(obb_pkg::MAX_KEYS + 1))
endmodule
`default_nettype wire
